/* hw/rtl/nrd_pkg.sv */
// Package for the nonce report deframer with duplicate filter.
// Holds widths, reset constants, frame positions and shared types.
// No dependencies.
package nrd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned NonceW    = 32;
  localparam int unsigned ChipW     = 4;
  localparam int unsigned PosW      = 3;
  localparam int unsigned HistDepth = 16;

  localparam logic [ByteW-1:0] SyncReset = 8'h55;
  localparam int unsigned      ReportBit = 7;

  localparam logic [PosW-1:0] PosChip  = 3'd1;
  localparam logic [PosW-1:0] PosFlag  = 3'd2;
  localparam logic [PosW-1:0] PosNonce0 = 3'd4;
  localparam logic [PosW-1:0] PosNonce1 = 3'd5;
  localparam logic [PosW-1:0] PosNonce2 = 3'd6;
  localparam logic [PosW-1:0] PosLast  = 3'd7;

  typedef struct packed {
    logic              report;
    logic [NonceW-1:0] nonce;
    logic [ChipW-1:0]  chip;
  } frame_status_t;

  typedef enum logic [2:0] {
    StRun    = 3'b001,
    StCheck  = 3'b010,
    StDecide = 3'b100
  } state_e;

endpackage

/* hw/rtl/nrd_cell.sv */
// One history cell: holds a recent nonce and passes the probe and its
// running match flag to the next cell each cycle. Depends on nrd_pkg.
module nrd_cell import nrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NonceW-1:0] probe_i,
  input  logic              hit_i,
  input  logic              shift_i,
  input  logic [NonceW-1:0] entry_i,
  output logic [NonceW-1:0] probe_o,
  output logic              hit_o,
  output logic [NonceW-1:0] entry_o
);

  logic [NonceW-1:0] entry_q, entry_d;
  logic [NonceW-1:0] probe_q;
  logic              hit_q, hit_d;

  assign entry_d = shift_i ? entry_i : entry_q;
  assign hit_d   = hit_i | (probe_i == entry_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_i;
  end

  assign probe_o = probe_q;
  assign hit_o   = hit_q;
  assign entry_o = entry_q;

endmodule

/* hw/rtl/nrd_deframer.sv */
// Byte deframer: hunts for the sync byte, collects the 8-byte frame and
// flags a completed nonce report. Depends on nrd_pkg.
module nrd_deframer import nrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [ByteW-1:0] sync_byte_i,
  output frame_status_t    status_o
);

  logic              in_frame_q, in_frame_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ChipW-1:0]  chip_q, chip_d;
  logic              flag_q, flag_d;
  logic [NonceW-1:0] nonce_q, nonce_d;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    chip_d     = chip_q;
    flag_d     = flag_q;
    nonce_d    = nonce_q;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == sync_byte_i) begin
          in_frame_d = 1'b1;
          pos_d      = PosChip;
        end
      end else begin
        case (pos_q)
          PosChip:   chip_d  = rx_byte_i[ChipW-1:0];
          PosFlag:   flag_d  = rx_byte_i[ReportBit];
          PosNonce0: nonce_d = {{(NonceW-ByteW){1'b0}}, rx_byte_i};
          PosNonce1: nonce_d = nonce_q | {{(NonceW-2*ByteW){1'b0}}, rx_byte_i, {ByteW{1'b0}}};
          PosNonce2: nonce_d = nonce_q | {{ByteW{1'b0}}, rx_byte_i, {(2*ByteW){1'b0}}};
          PosLast:   nonce_d = nonce_q | {rx_byte_i, {(NonceW-ByteW){1'b0}}};
          default:   ;
        endcase
        if (pos_q == PosLast) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      chip_q     <= '0;
      flag_q     <= 1'b0;
      nonce_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      chip_q     <= chip_d;
      flag_q     <= flag_d;
      nonce_q    <= nonce_d;
    end
  end

  assign status_o.report = accept_i & in_frame_q & (pos_q == PosLast) & flag_q;
  assign status_o.nonce  = nonce_q;
  assign status_o.chip   = chip_q;

endmodule

/* hw/rtl/nonce_report_deframer_dedup_core.sv */
// Top level of the nonce report deframer with duplicate filter.
// Depends on nrd_pkg, nrd_deframer and nrd_cell.
// Usage:
// - Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one received
//   byte per transaction. Outside a report check a byte is taken every cycle.
// - Bytes before a sync byte are dropped; a sync byte opens an 8-byte frame.
// - When byte 7 of a frame with bit 7 of byte 2 set is taken, the nonce is
//   sent down a chain of HISTORY_DEPTH cells, one cell per cycle. Input is
//   held off while the probe walks the chain.
// - A new nonce is shifted into the head of the chain and presented on the
//   output channel (out_valid_o/out_ready_i) once the probe has left the
//   chain; a duplicate is dropped.
// - If the receiver stalls, input continues until the next report check
//   finds a new nonce; the block then waits until the output register frees.
// - Configuration (cfg_valid_i/cfg_ready_o, cfg_data_i) sets the sync byte;
//   always ready; to be written only while idle, not enforced by the block.
// - Reset clears the frame state, the sync byte to 0x55 and every history
//   cell to zero.
module nonce_report_deframer_dedup_core import nrd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ByteW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NonceW-1:0] nonce_value_o,
  output logic [ChipW-1:0]  chip_number_o
);

  localparam int unsigned CntW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ByteW-1:0]  sync_q;
  logic              in_accept;
  frame_status_t     frame;
  logic              out_free;
  logic              hist_shift;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic [NonceW-1:0] out_nonce_q;
  logic [ChipW-1:0]  out_chip_q;

  logic [NonceW-1:0] probe_chain [HISTORY_DEPTH+1];
  logic              hit_chain   [HISTORY_DEPTH+1];
  logic [NonceW-1:0] entry_chain [HISTORY_DEPTH+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sync_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == StRun);
  assign in_accept  = in_valid_i & in_ready_o;

  nrd_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .sync_byte_i (sync_q),
    .status_o    (frame)
  );

  assign probe_chain[0] = frame.nonce;
  assign hit_chain[0]   = 1'b0;
  assign entry_chain[0] = frame.nonce;

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    nrd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe_chain[k]),
      .hit_i   (hit_chain[k]),
      .shift_i (hist_shift),
      .entry_i (entry_chain[k]),
      .probe_o (probe_chain[k+1]),
      .hit_o   (hit_chain[k+1]),
      .entry_o (entry_chain[k+1])
    );
  end

  assign out_free   = ~out_valid_q | out_ready_i;
  assign hist_shift = (state_q == StDecide) & ~hit_chain[HISTORY_DEPTH] & out_free;
  assign out_load   = hist_shift;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StRun: begin
        if (frame.report) begin
          state_d = StCheck;
          cnt_d   = '0;
        end
      end
      StCheck: begin
        if (cnt_q == CntW'(HISTORY_DEPTH - 1)) begin
          state_d = StDecide;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDecide: begin
        if (hit_chain[HISTORY_DEPTH] || out_free) begin
          state_d = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_nonce_q <= frame.nonce;
      out_chip_q  <= frame.chip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign nonce_value_o = out_nonce_q;
  assign chip_number_o = out_chip_q;

`ifndef NO_ASSERTIONS
  a_report_starts_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.report |=> (state_q == StCheck) && (cnt_q == '0))
    else $error("report frame did not start a history check");

  a_decide_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) && !$past(state_q == StCheck) |=> 1'b1 ##0
    ($past(cnt_q) == '0))
    else $error("check counter not cleared at start of walk");

  a_decide_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) && (state_d == StDecide) |-> (cnt_q == CntW'(HISTORY_DEPTH - 1)))
    else $error("decision reached before probe left the chain");

  a_shift_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_shift |-> (!out_valid_q || out_ready_i))
    else $error("history shifted while output register still held");

  a_pending_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_nonce_q))
    else $error("pending result lost or changed");
`endif

endmodule
